// ===== src/nab_pkg.sv =====
// Shared types and constants of the 3x3 neighbour average blur.
package nab_pkg;

  localparam int unsigned CH_W        = 8;
  localparam int unsigned ROW_W       = 12;
  localparam int unsigned COL_W       = 10;
  localparam int unsigned FW_W        = 11;
  localparam int unsigned FH_W        = 13;
  localparam int unsigned HEIGHT_MAX  = 4096;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 13;
  localparam int unsigned OUTQ_DEPTH  = 8;
  localparam int unsigned OUTQ_PTR_W  = $clog2(OUTQ_DEPTH);
  localparam int unsigned OUTQ_CNT_W  = $clog2(OUTQ_DEPTH + 1);
  localparam int unsigned DIV_SHIFT   = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH  = 2'd0,
    CFG_FRAME_HEIGHT = 2'd1
  } cfg_idx_e;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } pix_t;

  typedef struct packed {
    logic [CH_W-1:0]  out_red;
    logic [CH_W-1:0]  out_green;
    logic [CH_W-1:0]  out_blue;
    logic [ROW_W-1:0] out_row;
    logic [COL_W-1:0] out_col;
    logic             frame_last;
  } result_t;

  typedef struct packed {
    pix_t older;
    pix_t newer;
  } line_t;

  typedef struct packed {
    logic             interior;
    logic             border;
    logic             last;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
  } ctrl_t;

endpackage

// ===== src/neighbour_average_blur_3x3_top.sv =====
// Top level of the 3x3 neighbour average blur: counters, config, pipeline.
//
//   channel | valid / ready           | payload
//   in      | in_valid_i / in_ready_o   | in_data_i   (red, green, blue)
//   out     | out_valid_o / out_ready_i | out_data_o  (pixel, row, col, frame_last)
//   cfg     | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
// One pixel per cycle: a line buffer read issues on accept, the window and
// average follow in the next cycle and push one or two results into an
// eight-entry queue. The output side drains one result per cycle while
// out_ready_i is high; input stalls only when the queue backs up. Reset clears
// counters, window and queue, not line buffers. Width or height writes restart the frame.
module neighbour_average_blur_3x3_top #(
  parameter int unsigned MAX_WIDTH = 1024
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  nab_pkg::pix_t                   in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output nab_pkg::result_t                out_data_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [nab_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [nab_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import nab_pkg::*;

  localparam int unsigned AW = $clog2(MAX_WIDTH);
  localparam int unsigned WW = $clog2(MAX_WIDTH + 1);

  logic [FW_W-1:0]       fwidth_q, fwidth_d;
  logic [FH_W-1:0]       fheight_q, fheight_d;
  logic [ROW_W-1:0]      row_q, row_d;
  logic [AW-1:0]         col_q, col_d;
  logic [WW-1:0]         eff_w;
  logic [FH_W-1:0]       eff_h;
  logic                  last_col, last_row;
  logic                  in_fire, cfg_fire, cfg_hit;
  ctrl_t                 ctrl;

  logic                  s1_valid_q;
  pix_t                  s1_pix_q;
  ctrl_t                 s1_ctrl_q;
  logic [AW-1:0]         s1_col_q;

  line_t                 rd_line;
  logic                  push_a, push_b;
  result_t               data_a, data_b;
  logic [OUTQ_CNT_W-1:0] q_count;
  logic [OUTQ_CNT_W+1:0] q_need;

  assign cfg_ready_o = 1'b1;
  assign cfg_fire    = cfg_valid_i && cfg_ready_o;
  assign in_fire     = in_valid_i && in_ready_o;

  assign q_need     = (OUTQ_CNT_W+2)'(q_count) + (s1_valid_q ? (OUTQ_CNT_W+2)'(4)
                                                             : (OUTQ_CNT_W+2)'(2));
  assign in_ready_o = (q_need <= (OUTQ_CNT_W+2)'(OUTQ_DEPTH));

  always_comb begin
    if (fwidth_q == '0) begin
      eff_w = WW'(1);
    end else if (32'(fwidth_q) > MAX_WIDTH) begin
      eff_w = WW'(MAX_WIDTH);
    end else begin
      eff_w = WW'(fwidth_q);
    end
    if (fheight_q == '0) begin
      eff_h = FH_W'(1);
    end else if (32'(fheight_q) > HEIGHT_MAX) begin
      eff_h = FH_W'(HEIGHT_MAX);
    end else begin
      eff_h = fheight_q;
    end
  end

  assign last_col = (32'(col_q) + 32'd1 >= 32'(eff_w));
  assign last_row = (FH_W'(row_q) + FH_W'(1) >= eff_h);

  always_comb begin
    ctrl.interior = (row_q >= ROW_W'(2)) && (32'(col_q) >= 32'd2);
    ctrl.border   = (row_q == '0) || (col_q == '0) || last_row || last_col;
    ctrl.last     = last_row && last_col;
    ctrl.row      = row_q;
    ctrl.col      = COL_W'(col_q);
  end

  always_comb begin
    fwidth_d  = fwidth_q;
    fheight_d = fheight_q;
    cfg_hit   = 1'b0;
    if (cfg_fire) begin
      unique case (cfg_index_i)
        CFG_FRAME_WIDTH: begin
          fwidth_d = FW_W'(cfg_data_i);
          cfg_hit  = 1'b1;
        end
        CFG_FRAME_HEIGHT: begin
          fheight_d = cfg_data_i;
          cfg_hit   = 1'b1;
        end
        default: begin
          cfg_hit = 1'b0;
        end
      endcase
    end
  end

  always_comb begin
    row_d = row_q;
    col_d = col_q;
    if (cfg_hit) begin
      row_d = '0;
      col_d = '0;
    end else if (in_fire) begin
      if (last_col) begin
        col_d = '0;
        row_d = last_row ? '0 : row_q + ROW_W'(1);
      end else begin
        col_d = col_q + AW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwidth_q   <= FW_W'(1024);
      fheight_q  <= FH_W'(768);
      row_q      <= '0;
      col_q      <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      fwidth_q   <= fwidth_d;
      fheight_q  <= fheight_d;
      row_q      <= row_d;
      col_q      <= col_d;
      s1_valid_q <= in_fire;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_pix_q  <= in_data_i;
      s1_ctrl_q <= ctrl;
      s1_col_q  <= col_q;
    end
  end

  nab_linebuf #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_linebuf (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (in_fire),
    .rd_addr_i (col_q),
    .wr_en_i   (s1_valid_q),
    .wr_addr_i (s1_col_q),
    .wr_pix_i  (s1_pix_q),
    .rd_line_o (rd_line)
  );

  nab_window u_window (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (s1_valid_q),
    .pix_i    (s1_pix_q),
    .line_i   (rd_line),
    .ctrl_i   (s1_ctrl_q),
    .push_a_o (push_a),
    .data_a_o (data_a),
    .push_b_o (push_b),
    .data_b_o (data_b)
  );

  nab_outq u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_a_i    (push_a),
    .data_a_i    (data_a),
    .push_b_i    (push_b),
    .data_b_i    (data_b),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .count_o     (q_count)
  );

endmodule

// ===== src/nab_linebuf.sv =====
// Two-line buffer memory with registered read and write-to-read forwarding.
module nab_linebuf #(
  parameter int unsigned MAX_WIDTH = 1024
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         rd_en_i,
  input  logic [$clog2(MAX_WIDTH)-1:0] rd_addr_i,
  input  logic                         wr_en_i,
  input  logic [$clog2(MAX_WIDTH)-1:0] wr_addr_i,
  input  nab_pkg::pix_t                wr_pix_i,
  output nab_pkg::line_t               rd_line_o
);
  import nab_pkg::*;

  line_t mem [MAX_WIDTH];
  line_t rd_q;
  line_t fwd_q;
  logic  fwd_sel_q;
  line_t wr_line;

  assign rd_line_o = fwd_sel_q ? fwd_q : rd_q;

  always_comb begin
    wr_line.older = rd_line_o.newer;
    wr_line.newer = wr_pix_i;
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_q <= mem[rd_addr_i];
    end
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_line;
    end
  end

  always_ff @(posedge clk_i) begin
    fwd_q <= wr_line;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_sel_q <= 1'b0;
    end else if (rd_en_i) begin
      fwd_sel_q <= wr_en_i && (wr_addr_i == rd_addr_i);
    end
  end

endmodule

// ===== src/nab_window.sv =====
// Window registers and the eight-neighbour average.
module nab_window (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  nab_pkg::pix_t    pix_i,
  input  nab_pkg::line_t   line_i,
  input  nab_pkg::ctrl_t   ctrl_i,
  output logic             push_a_o,
  output nab_pkg::result_t data_a_o,
  output logic             push_b_o,
  output nab_pkg::result_t data_b_o
);
  import nab_pkg::*;

  pix_t win_q [3][2];
  pix_t col_new [3];
  pix_t avg;

  function automatic logic [CH_W-1:0] avg8(
    input logic [CH_W-1:0] a, input logic [CH_W-1:0] b,
    input logic [CH_W-1:0] c, input logic [CH_W-1:0] d,
    input logic [CH_W-1:0] e, input logic [CH_W-1:0] f,
    input logic [CH_W-1:0] g, input logic [CH_W-1:0] h
  );
    logic [CH_W-1:0] s;
    s = CH_W'(a >> DIV_SHIFT) + CH_W'(b >> DIV_SHIFT) + CH_W'(c >> DIV_SHIFT)
      + CH_W'(d >> DIV_SHIFT) + CH_W'(e >> DIV_SHIFT) + CH_W'(f >> DIV_SHIFT)
      + CH_W'(g >> DIV_SHIFT) + CH_W'(h >> DIV_SHIFT);
    return s;
  endfunction

  always_comb begin
    col_new[0] = line_i.older;
    col_new[1] = line_i.newer;
    col_new[2] = pix_i;
    avg.red   = avg8(win_q[0][0].red, win_q[0][1].red, col_new[0].red,
                     win_q[1][0].red, col_new[1].red,
                     win_q[2][0].red, win_q[2][1].red, col_new[2].red);
    avg.green = avg8(win_q[0][0].green, win_q[0][1].green, col_new[0].green,
                     win_q[1][0].green, col_new[1].green,
                     win_q[2][0].green, win_q[2][1].green, col_new[2].green);
    avg.blue  = avg8(win_q[0][0].blue, win_q[0][1].blue, col_new[0].blue,
                     win_q[1][0].blue, col_new[1].blue,
                     win_q[2][0].blue, win_q[2][1].blue, col_new[2].blue);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        win_q[i][0] <= '0;
        win_q[i][1] <= '0;
      end
    end else if (valid_i) begin
      for (int i = 0; i < 3; i++) begin
        win_q[i][0] <= win_q[i][1];
        win_q[i][1] <= col_new[i];
      end
    end
  end

  always_comb begin
    push_a_o            = valid_i && ctrl_i.interior;
    data_a_o.out_red    = avg.red;
    data_a_o.out_green  = avg.green;
    data_a_o.out_blue   = avg.blue;
    data_a_o.out_row    = ctrl_i.row - ROW_W'(1);
    data_a_o.out_col    = ctrl_i.col - COL_W'(1);
    data_a_o.frame_last = 1'b0;

    push_b_o            = valid_i && ctrl_i.border;
    data_b_o.out_red    = pix_i.red;
    data_b_o.out_green  = pix_i.green;
    data_b_o.out_blue   = pix_i.blue;
    data_b_o.out_row    = ctrl_i.row;
    data_b_o.out_col    = ctrl_i.col;
    data_b_o.frame_last = ctrl_i.last;
  end

endmodule

// ===== src/nab_outq.sv =====
// Result queue taking up to two items per cycle and giving one while out_ready_i is high.
module nab_outq (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            push_a_i,
  input  nab_pkg::result_t                data_a_i,
  input  logic                            push_b_i,
  input  nab_pkg::result_t                data_b_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output nab_pkg::result_t                out_data_o,
  output logic [nab_pkg::OUTQ_CNT_W-1:0]  count_o
);
  import nab_pkg::*;

  result_t                 q_mem [OUTQ_DEPTH];
  logic [OUTQ_PTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [OUTQ_PTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [OUTQ_CNT_W-1:0]   cnt_q, cnt_d;
  logic [OUTQ_PTR_W-1:0]   b_ptr;
  logic                    pop;
  logic [1:0]              n_push;

  assign out_valid_o = (cnt_q != '0);
  assign out_data_o  = q_mem[rd_ptr_q];
  assign count_o     = cnt_q;
  assign pop         = out_valid_o && out_ready_i;
  assign n_push      = 2'(push_a_i) + 2'(push_b_i);
  assign b_ptr       = push_a_i ? wr_ptr_q + OUTQ_PTR_W'(1) : wr_ptr_q;

  always_comb begin
    wr_ptr_d = wr_ptr_q + OUTQ_PTR_W'(n_push);
    rd_ptr_d = rd_ptr_q + OUTQ_PTR_W'(pop);
    cnt_d    = cnt_q + OUTQ_CNT_W'(n_push) - OUTQ_CNT_W'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_a_i) begin
      q_mem[wr_ptr_q] <= data_a_i;
    end
    if (push_b_i) begin
      q_mem[b_ptr] <= data_b_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

// ===== src/nab_checker.sv =====
// Port-level checks of the blur top level, bound to it.
module nab_checker (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_ready_o,
  input logic             out_valid_o,
  input logic             out_ready_i,
  input nab_pkg::result_t out_data_o
);
  import nab_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("out item changed while stalled");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input stalled with no item waiting at the output");

  a_out_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o, 2))
    else $error("output item without an input item two cycles earlier");

endmodule

bind neighbour_average_blur_3x3_top nab_checker u_nab_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

// ===== tb/neighbour_average_blur_3x3_chk.sv =====
// Checker for the 3x3 neighbour blur: tracks the pixel stream and compares every result item.
module neighbour_average_blur_3x3_chk
  import nab_pkg::*;
#(
  parameter int unsigned MAX_WIDTH = 1024
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_ready_i,
  input  pix_t                  in_data_i,
  input  logic                  out_valid_i,
  input  logic                  out_ready_i,
  input  result_t               out_data_i,
  input  logic                  cfg_valid_i,
  input  logic                  cfg_ready_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output int unsigned           mismatch_count_o,
  output int unsigned           results_owed_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NEIGHBOUR_DIV = 8;
  localparam int unsigned HEIGHT_LIMIT  = 4096;
  localparam int unsigned WIDTH_RESET   = 1024;
  localparam int unsigned HEIGHT_RESET  = 768;

  pix_t             older_row [MAX_WIDTH];
  pix_t             newer_row [MAX_WIDTH];
  pix_t             win       [3][3];
  logic [ROW_W-1:0] row_pos;
  logic [COL_W-1:0] col_pos;
  logic [FW_W-1:0]  frame_width;
  logic [FH_W-1:0]  frame_height;
  result_t          owed_results_q [$];

  function automatic string fmt_result(input result_t x);
    return $sformatf("rgb %02h %02h %02h row %0d col %0d last %0b",
                     x.out_red, x.out_green, x.out_blue, x.out_row, x.out_col, x.frame_last);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : blur_model
    int unsigned     w, h, r, c, idx, i, j;
    logic [CH_W-1:0] sum_red, sum_green, sum_blue;
    result_t         res, want;
    if (!rst_ni) begin
      for (i = 0; i < MAX_WIDTH; i++) begin
        older_row[i] = '0;
        newer_row[i] = '0;
      end
      for (i = 0; i < 3; i++) begin
        for (j = 0; j < 3; j++) begin
          win[i][j] = '0;
        end
      end
      row_pos          = '0;
      col_pos          = '0;
      frame_width      = FW_W'(WIDTH_RESET);
      frame_height     = FH_W'(HEIGHT_RESET);
      owed_results_q.delete();
      mismatch_count_o = 0;
      results_owed_o   = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (owed_results_q.size() == 0) begin
          mismatch_count_o++;
          $display("%0t: result mismatch: expected none, got %s", $time,
                   fmt_result(out_data_i));
        end else begin
          want = owed_results_q.pop_front();
          if (want.out_red !== out_data_i.out_red || want.out_green !== out_data_i.out_green ||
              want.out_blue !== out_data_i.out_blue || want.out_row !== out_data_i.out_row ||
              want.out_col !== out_data_i.out_col ||
              want.frame_last !== out_data_i.frame_last) begin
            mismatch_count_o++;
            $display("%0t: result mismatch: expected %s, got %s", $time, fmt_result(want),
                     fmt_result(out_data_i));
          end
        end
      end

      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_FRAME_WIDTH: begin
            frame_width = cfg_data_i[FW_W-1:0];
            row_pos     = '0;
            col_pos     = '0;
          end
          CFG_FRAME_HEIGHT: begin
            frame_height = cfg_data_i[FH_W-1:0];
            row_pos      = '0;
            col_pos      = '0;
          end
          default: begin
          end
        endcase
      end

      if (in_valid_i && in_ready_i) begin
        w = frame_width;
        if (w == 0) w = 1;
        if (w > MAX_WIDTH) w = MAX_WIDTH;
        h = frame_height;
        if (h == 0) h = 1;
        if (h > HEIGHT_LIMIT) h = HEIGHT_LIMIT;
        r   = row_pos;
        c   = col_pos;
        idx = c % MAX_WIDTH;

        for (i = 0; i < 3; i++) begin
          win[i][0] = win[i][1];
          win[i][1] = win[i][2];
        end
        win[0][2]      = older_row[idx];
        win[1][2]      = newer_row[idx];
        win[2][2]      = in_data_i;
        older_row[idx] = newer_row[idx];
        newer_row[idx] = in_data_i;

        if (r >= 2 && c >= 2 && r < h && c < w) begin
          sum_red   = '0;
          sum_green = '0;
          sum_blue  = '0;
          for (i = 0; i < 3; i++) begin
            for (j = 0; j < 3; j++) begin
              if (!(i == 1 && j == 1)) begin
                sum_red   += CH_W'(win[i][j].red / NEIGHBOUR_DIV);
                sum_green += CH_W'(win[i][j].green / NEIGHBOUR_DIV);
                sum_blue  += CH_W'(win[i][j].blue / NEIGHBOUR_DIV);
              end
            end
          end
          res.out_red    = sum_red;
          res.out_green  = sum_green;
          res.out_blue   = sum_blue;
          res.out_row    = ROW_W'(r - 1);
          res.out_col    = COL_W'(c - 1);
          res.frame_last = 1'b0;
          owed_results_q.push_back(res);
        end

        if (r == 0 || c == 0 || r + 1 >= h || c + 1 >= w) begin
          res.out_red    = in_data_i.red;
          res.out_green  = in_data_i.green;
          res.out_blue   = in_data_i.blue;
          res.out_row    = ROW_W'(r);
          res.out_col    = COL_W'(c);
          res.frame_last = (r + 1 >= h) && (c + 1 >= w);
          owed_results_q.push_back(res);
        end

        if (c + 1 >= w) begin
          col_pos = '0;
          row_pos = (r + 1 >= h) ? '0 : ROW_W'(r + 1);
        end else begin
          col_pos = COL_W'(c + 1);
        end
      end

      results_owed_o = owed_results_q.size();
    end
  end

endmodule

// ===== tb/neighbour_average_blur_3x3_top_tb.sv =====
// Testbench top for the 3x3 neighbour blur: drives pixels and register writes, gives the verdict.
module neighbour_average_blur_3x3_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import nab_pkg::*;

  localparam int unsigned MAX_WIDTH         = 1024;
  localparam int unsigned CLK_PERIOD        = 10;
  localparam int unsigned RESET_FRAME_ITEMS = 200;
  localparam int unsigned RANDOM_ITEMS      = 1150;
  localparam int unsigned DRAIN_CYCLES      = 16;
  localparam int unsigned HOLD_CYCLES       = 300;
  localparam int unsigned PHASE_CAP         = 300;
  localparam int unsigned RUN_LIMIT_NS      = 5_000_000;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_ready_o;
  pix_t                  in_data_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  result_t               out_data_o;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  int unsigned           mismatch_count;
  int unsigned           results_owed;
  int unsigned           send_idle_pct;
  int unsigned           recv_stall_pct;
  int unsigned           hold_off_left;

  neighbour_average_blur_3x3_top #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  neighbour_average_blur_3x3_chk #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_chk (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_i       (in_ready_o),
    .in_data_i        (in_data_i),
    .out_valid_i      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .out_data_i       (out_data_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_i      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .mismatch_count_o (mismatch_count),
    .results_owed_o   (results_owed)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  always @(negedge clk_i) begin
    if (hold_off_left != 0) begin
      hold_off_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  function automatic pix_t random_pixel();
    logic [31:0] bits;
    bits = $urandom;
    return bits[$bits(pix_t)-1:0];
  endfunction

  task automatic send_pixel(input pix_t px);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= px;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (results_owed != 0) @(negedge clk_i);
  endtask

  task automatic quiesce();
    drain_results();
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  initial begin
    #(RUN_LIMIT_NS);
    $display("end of test: mismatches");
    $finish;
  end

  initial begin : stimulus
    int unsigned phase, rand_sent, n_items, w_pick, h_pick, w_eff, h_eff, frame, k;
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    in_data_i      = '0;
    out_ready_i    = 1'b0;
    cfg_valid_i    = 1'b0;
    cfg_index_i    = CFG_FRAME_WIDTH;
    cfg_data_i     = '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_off_left  = 0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // part of the first row at the reset frame size
    send_idle_pct  = 16;
    recv_stall_pct = 16;
    repeat (RESET_FRAME_ITEMS) send_pixel(random_pixel());
    quiesce();

    // smallest frame with an interior pixel, all channels at full scale
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    write_reg(CFG_FRAME_WIDTH, 13'd3);
    write_reg(CFG_FRAME_HEIGHT, 13'd3);
    repeat (9) send_pixel({8'hFF, 8'hFF, 8'hFF});

    // unknown register indexes leave the frame running
    send_pixel({8'h07, 8'h08, 8'h0F});
    send_pixel({8'h08, 8'h07, 8'h10});
    send_pixel({8'h00, 8'hFF, 8'h80});
    send_pixel({8'hFF, 8'h00, 8'h7F});
    quiesce();
    write_reg(CFG_SPARE_LO, 13'h1FFF);
    write_reg(CFG_SPARE_HI, 13'h0001);
    repeat (5) send_pixel(random_pixel());
    quiesce();

    // zero sizes act as one pixel
    write_reg(CFG_FRAME_WIDTH, 13'd0);
    write_reg(CFG_FRAME_HEIGHT, 13'd0);
    repeat (2) send_pixel(random_pixel());
    quiesce();

    // oversize values clamp; the frame is cut short by the next write
    write_reg(CFG_FRAME_WIDTH, 13'd2047);
    write_reg(CFG_FRAME_HEIGHT, 13'd8191);
    repeat (3) send_pixel(random_pixel());
    quiesce();

    // one column, through the wrap
    write_reg(CFG_FRAME_WIDTH, 13'd1);
    write_reg(CFG_FRAME_HEIGHT, 13'd4);
    repeat (10) send_pixel(random_pixel());
    quiesce();

    phase     = 0;
    rand_sent = 0;
    while (rand_sent < RANDOM_ITEMS) begin
      case (phase % 4)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 88;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 88;
        end
        default: begin
          send_idle_pct  = 16;
          recv_stall_pct = 16;
        end
      endcase

      w_pick = $urandom_range(9);
      case (w_pick)
        0, 1, 2: w_eff = w_pick;
        9:       w_eff = $urandom_range(17, 64);
        default: w_eff = $urandom_range(3, 16);
      endcase
      h_pick = $urandom_range(9);
      h_eff  = (h_pick == 9) ? $urandom_range(10, 20) : h_pick;
      write_reg(CFG_FRAME_WIDTH, {2'($urandom), 11'(w_eff)});
      write_reg(CFG_FRAME_HEIGHT, 13'(h_eff));
      if (w_eff == 0) w_eff = 1;
      if (h_eff == 0) h_eff = 1;

      frame   = w_eff * h_eff;
      n_items = frame * $urandom_range(1, 2) + $urandom_range(0, frame - 1);
      if (n_items > PHASE_CAP) n_items = PHASE_CAP;
      if (phase == 0 && n_items < 64) n_items = 64;

      for (k = 0; k < n_items; k++) begin
        send_pixel(random_pixel());
        if (phase == 0 && k == 0) begin
          hold_off_left = HOLD_CYCLES;
        end else if (phase == 0 && k == n_items / 2) begin
          drain_results();
        end else if ($urandom_range(249) == 0) begin
          drain_results();
        end
      end
      rand_sent += n_items;
      phase++;
      quiesce();
    end

    if (mismatch_count == 0 && results_owed == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
